// File: rtl/rpnh_pkg.sv
`timescale 1ns / 1ps
package rpnh_pkg;

    localparam int W_COORD = 16;
    localparam int W_DIFF  = W_COORD + 1;
    localparam int W_PROD  = 2 * W_DIFF;
    localparam int W_ACC   = W_PROD + 2;
    localparam int W_NUM   = 35;
    localparam int W_DEN   = 33;
    localparam int W_Q     = 32;
    localparam int W_REM   = W_DEN + 1;
    localparam int W_CIDX  = 3;
    localparam int W_STEP  = 3;
    localparam int W_CNT   = 5;
    localparam int W_FRAC  = 16;

    localparam logic [W_STEP-1:0] LAST_STEP = W_STEP'(5);
    localparam logic [W_Q-1:0]    Q_SAT     = '1;

    typedef enum logic [W_CIDX-1:0] {
        CFG_QUERY_MODE  = 3'd0,
        CFG_ORIGIN_X    = 3'd1,
        CFG_ORIGIN_Y    = 3'd2,
        CFG_DIRECTION_X = 3'd3,
        CFG_DIRECTION_Y = 3'd4
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_MUL,
        S_ACC,
        S_NORM,
        S_CHECK,
        S_DIV,
        S_UPDATE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic signed [W_COORD-1:0] vertex_x;
        logic signed [W_COORD-1:0] vertex_y;
        logic                      polygon_end;
        logic                      query_end;
    } t_in_req;

    typedef struct packed {
        logic           hit_found;
        logic [W_Q-1:0] hit_distance;
    } t_out_req;

endpackage

// File: rtl/ray_polygon_nearest_hit.sv
`timescale 1ns / 1ps
// Casts a 2D ray from the configured origin along the configured direction against polygon
// edges built from a stream of Q12.4 vertices, and on the request that ends a query returns
// whether an edge was hit and the least ray parameter t as unsigned Q16.16, saturated. One
// shared 17 by 17 multiplier forms the three cross products of an edge, one product at a time,
// and a radix-2 divider then finds t for an edge that qualifies, unless its t saturates. A vertex
// request opens no edge, the edge to it, or also the closing edge; the input stalls until they
// are done. A pending result does not block new vertices unless a second query ends first.
module ray_polygon_nearest_hit
    import rpnh_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  t_in_req             i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output t_out_req            o_out_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [W_CIDX-1:0]   i_cfg_index,
    input  logic [W_COORD-1:0]  i_cfg_data
);

    t_state r_state, n_state;

    logic                      r_mode;
    logic signed [W_COORD-1:0] r_ox, r_oy, r_dx, r_dy;

    logic signed [W_COORD-1:0] r_first_x, r_first_y, r_prev_x, r_prev_y;
    logic                      r_open;
    logic signed [W_COORD-1:0] r_ax, r_ay, r_vx, r_vy;
    logic                      r_has_b, r_qend, r_sel;
    logic                      n_sel;

    logic signed [W_DIFF-1:0]  r_cx, r_cy, r_wx, r_wy;
    logic [W_STEP-1:0]         r_step;
    logic signed [W_PROD-1:0]  r_prod;
    logic signed [W_ACC-1:0]   r_d, r_tn, r_un;
    logic signed [W_ACC-1:0]   r_dm, r_tm, r_um;
    logic [W_Q-1:0]            r_qv;
    logic [W_Q-1:0]            r_best;
    logic                      r_have;
    logic                      r_out_valid;
    t_out_req                  r_out;

    logic signed [W_COORD-1:0] ex_ax, ex_ay, ex_bx, ex_by;
    logic signed [W_DIFF-1:0]  mul_a, mul_b;
    logic signed [W_ACC-1:0]   prod_ext;
    logic                      accept, qualify, sat, div_start, div_done, emit;
    logic [W_Q-1:0]            div_quot;
    logic [51:0]               sat_num, sat_den;

    assign accept      = i_in_valid && o_in_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
            r_ox   <= '0;
            r_oy   <= '0;
            r_dx   <= '0;
            r_dy   <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_QUERY_MODE:  r_mode <= i_cfg_data[0];
                CFG_ORIGIN_X:    r_ox   <= i_cfg_data;
                CFG_ORIGIN_Y:    r_oy   <= i_cfg_data;
                CFG_DIRECTION_X: r_dx   <= i_cfg_data;
                CFG_DIRECTION_Y: r_dy   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign ex_ax = r_sel ? r_vx : r_ax;
    assign ex_ay = r_sel ? r_vy : r_ay;
    assign ex_bx = r_sel ? r_first_x : r_vx;
    assign ex_by = r_sel ? r_first_y : r_vy;

    always_comb begin
        case (r_step)
            3'd0:    begin mul_a = W_DIFF'(r_dx); mul_b = r_cy; end
            3'd1:    begin mul_a = W_DIFF'(r_dy); mul_b = r_cx; end
            3'd2:    begin mul_a = r_wx;          mul_b = r_cy; end
            3'd3:    begin mul_a = r_wy;          mul_b = r_cx; end
            3'd4:    begin mul_a = r_wx;          mul_b = W_DIFF'(r_dy); end
            default: begin mul_a = r_wy;          mul_b = W_DIFF'(r_dx); end
        endcase
    end

    assign prod_ext = {{(W_ACC - W_PROD){r_prod[W_PROD-1]}}, r_prod};

    assign qualify = (r_dm != '0) && !r_um[W_ACC-1] && (r_um <= r_dm)
                     && (r_tm > 0) && !(r_mode && (r_tm >= r_dm));
    assign sat_num = {{(52 - W_NUM){1'b0}}, r_tm[W_NUM-1:0]};
    assign sat_den = {{(52 - W_DEN - W_FRAC){1'b0}}, r_dm[W_DEN-1:0], {W_FRAC{1'b0}}};
    assign sat     = sat_num >= sat_den;

    rpnh_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_tm[W_NUM-1:0]),
        .i_den   (r_dm[W_DEN-1:0]),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_sel     = r_sel;
        div_start = 1'b0;
        emit      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (r_open) begin
                        n_state = S_PREP;
                        n_sel   = 1'b0;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_PREP:  n_state = S_MUL;
            S_MUL:   n_state = S_ACC;
            S_ACC:   n_state = (r_step == LAST_STEP) ? S_NORM : S_MUL;
            S_NORM:  n_state = S_CHECK;
            S_CHECK: begin
                if (qualify && sat) begin
                    n_state = S_UPDATE;
                end else if (qualify) begin
                    n_state   = S_DIV;
                    div_start = 1'b1;
                end else if (!r_sel && r_has_b) begin
                    n_state = S_PREP;
                    n_sel   = 1'b1;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                if (!r_sel && r_has_b) begin
                    n_state = S_PREP;
                    n_sel   = 1'b1;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_qend) begin
                    n_state = S_IDLE;
                end else if (!r_out_valid || i_out_ready) begin
                    emit    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open      <= 1'b0;
            r_have      <= 1'b0;
            r_best      <= '0;
            r_out_valid <= 1'b0;
            r_sel       <= 1'b0;
            r_step      <= '0;
        end else begin
            r_sel <= n_sel;
            if (accept) begin
                r_open <= !(i_in_data.polygon_end || i_in_data.query_end);
            end
            if (r_state == S_PREP) begin
                r_step <= '0;
            end else if (r_state == S_ACC) begin
                r_step <= r_step + 1'b1;
            end
            if (r_state == S_UPDATE && (!r_have || r_qv < r_best)) begin
                r_have <= 1'b1;
                r_best <= r_qv;
            end
            if (emit) begin
                r_have      <= 1'b0;
                r_best      <= '0;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ax    <= r_prev_x;
            r_ay    <= r_prev_y;
            r_vx    <= i_in_data.vertex_x;
            r_vy    <= i_in_data.vertex_y;
            r_prev_x <= i_in_data.vertex_x;
            r_prev_y <= i_in_data.vertex_y;
            r_has_b <= r_open && (i_in_data.polygon_end || i_in_data.query_end);
            r_qend  <= i_in_data.query_end;
            if (!r_open) begin
                r_first_x <= i_in_data.vertex_x;
                r_first_y <= i_in_data.vertex_y;
            end
        end
        if (r_state == S_PREP) begin
            r_cx <= W_DIFF'(ex_bx) - W_DIFF'(ex_ax);
            r_cy <= W_DIFF'(ex_by) - W_DIFF'(ex_ay);
            r_wx <= W_DIFF'(ex_ax) - W_DIFF'(r_ox);
            r_wy <= W_DIFF'(ex_ay) - W_DIFF'(r_oy);
            r_d  <= '0;
            r_tn <= '0;
            r_un <= '0;
        end
        if (r_state == S_MUL) begin
            r_prod <= mul_a * mul_b;
        end
        if (r_state == S_ACC) begin
            case (r_step)
                3'd0:    r_d  <= r_d + prod_ext;
                3'd1:    r_d  <= r_d - prod_ext;
                3'd2:    r_tn <= r_tn + prod_ext;
                3'd3:    r_tn <= r_tn - prod_ext;
                3'd4:    r_un <= r_un + prod_ext;
                default: r_un <= r_un - prod_ext;
            endcase
        end
        if (r_state == S_NORM) begin
            r_dm <= r_d[W_ACC-1] ? -r_d  : r_d;
            r_tm <= r_d[W_ACC-1] ? -r_tn : r_tn;
            r_um <= r_d[W_ACC-1] ? -r_un : r_un;
        end
        if (r_state == S_CHECK) begin
            r_qv <= Q_SAT;
        end else if (r_state == S_DIV && div_done) begin
            r_qv <= div_quot;
        end
        if (emit) begin
            r_out.hit_found    <= r_have;
            r_out.hit_distance <= r_have ? r_best : '0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// File: rtl/rpnh_div.sv
`timescale 1ns / 1ps
module rpnh_div
    import rpnh_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [W_NUM-1:0] i_num,
    input  logic [W_DEN-1:0] i_den,
    output logic             o_done,
    output logic [W_Q-1:0]   o_quot
);

    logic [W_REM-1:0] r_rem;
    logic [W_Q-1:0]   r_q;
    logic [W_CNT-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [W_REM:0]   trial;
    logic [W_REM:0]   diff;
    logic             ge;

    assign trial = {r_rem, r_q[W_Q-1]};
    assign ge    = trial >= {2'b00, i_den};
    assign diff  = trial - {2'b00, i_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == '1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {{(W_REM - (W_NUM - W_FRAC)){1'b0}}, i_num[W_NUM-1:W_FRAC]};
            r_q   <= {i_num[W_FRAC-1:0], {(W_Q - W_FRAC){1'b0}}};
        end else if (r_busy) begin
            r_rem <= ge ? diff[W_REM-1:0] : trial[W_REM-1:0];
            r_q   <= {r_q[W_Q-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule
